// ===== design/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// shared types and constants for the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 35;
    localparam int MUL_W       = 2 * ELEM_W;
    localparam int DIM_REG_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int POS_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_WAIT,
        ST_OUT
    } mme_state_t;

    // operand travelling along the cell chain
    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic signed [ELEM_W-1:0] a;
    } mme_tok_t;

    typedef struct packed {
        logic shift;
        logic b_we;
    } mme_ctrl_t;

endpackage

// ===== design/mme_cell.sv =====
// ----------------------------------------------------------------------------
// mme_cell
// one column cell: holds a column of B, multiplies the passing A operand
// and accumulates one result; results shift towards the head of the chain
// ----------------------------------------------------------------------------
module mme_cell
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int IDX     = 0,
    localparam int DIM_W  = $clog2(MAX_DIM)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mme_ctrl_t                ctrl,
    input  logic [DIM_W-1:0]         b_wr_t,
    input  logic [DIM_W-1:0]         b_wr_col,
    input  logic signed [ELEM_W-1:0] b_wr_data,
    input  mme_tok_t                 tok_in,
    input  logic [DIM_W-1:0]         t_in,
    output mme_tok_t                 tok_out,
    output logic [DIM_W-1:0]         t_out,
    input  logic signed [PROD_W-1:0] acc_in,
    output logic signed [PROD_W-1:0] acc_out,
    output logic                     done
);

    logic signed [ELEM_W-1:0] b_mem [MAX_DIM];
    logic signed [ELEM_W-1:0] b_rd_reg;
    mme_tok_t                 tok_reg;
    logic [DIM_W-1:0]         t_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic                     mul_valid_reg;
    logic                     mul_first_reg;
    logic                     mul_last_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic signed [PROD_W-1:0] mul_ext;
    logic                     done_reg;

    // column store, one write and one read port
    always_ff @(posedge clk)
    begin
        if (ctrl.b_we && (b_wr_col == DIM_W'(IDX)))
        begin
            b_mem[b_wr_t] <= b_wr_data;
        end
        b_rd_reg <= b_mem[t_in];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg       <= '0;
            mul_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            tok_reg       <= tok_in;
            mul_valid_reg <= tok_reg.valid;
            done_reg      <= mul_valid_reg && mul_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_in;
        mul_reg       <= tok_reg.a * b_rd_reg;
        mul_first_reg <= tok_reg.first;
        mul_last_reg  <= tok_reg.last;
        acc_reg       <= acc_next;
    end

    assign mul_ext = {{(PROD_W-MUL_W){mul_reg[MUL_W-1]}}, mul_reg};

    always_comb
    begin
        if (ctrl.shift)
        begin
            acc_next = acc_in;
        end
        else if (mul_valid_reg)
        begin
            acc_next = mul_first_reg ? mul_ext : acc_reg + mul_ext;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    assign tok_out = tok_reg;
    assign t_out   = t_reg;
    assign acc_out = acc_reg;
    assign done    = done_reg;

endmodule

// ===== design/matrix_multiply_engine.sv =====
// Loading: one element per cycle, m*k elements of A then k*n of B.
// Compute: per result row, the k elements of the A row are issued, the engine waits while the last operand
//   crosses the cell chain, then the n results of the row are emitted (held while the output stalls).
// Throughput is set by the single A store read port and the one-row cell chain.
// Reset: sizes return to 1, load and row counters clear; stores keep no reset.
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// streaming C = A * B over signed Q8.8 elements, exact Q19.16 results
// ----------------------------------------------------------------------------
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DIM_REG_W-1:0]     cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ELEM_W-1:0] element,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [PROD_W-1:0] product,
    output logic [POS_W-1:0]         out_row,
    output logic [POS_W-1:0]         out_col,
    output logic                     last
);

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = DIM_REG_W + 1;

    function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = '0;
        end
        else if ({1'b0, v} > CMP_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM - 1);
        end
        else
        begin
            r = DIM_W'(v - DIM_REG_W'(1));
        end
        return r;
    endfunction

    logic [DIM_REG_W-1:0]     rows_m_reg;
    logic [DIM_REG_W-1:0]     inner_k_reg;
    logic [DIM_REG_W-1:0]     cols_n_reg;
    logic [DIM_W-1:0]         m_last;
    logic [DIM_W-1:0]         k_last;
    logic [DIM_W-1:0]         n_last;
    logic                     cfg_hit;

    mme_state_t               state_reg;
    mme_state_t               state_next;

    logic                     phase_b_reg;
    logic [DIM_W-1:0]         ld_i_reg;
    logic [DIM_W-1:0]         ld_j_reg;
    logic [DIM_W-1:0]         ld_i_last;
    logic [DIM_W-1:0]         ld_j_last;
    logic [AW-1:0]            a_wr_addr_reg;
    logic [AW-1:0]            a_rd_addr_reg;
    logic [DIM_W-1:0]         t_reg;
    logic [DIM_W-1:0]         row_reg;
    logic [DIM_W-1:0]         col_reg;

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic                     iss_valid_reg;
    logic                     iss_first_reg;
    logic                     iss_last_reg;
    logic [DIM_W-1:0]         iss_t_reg;

    logic                     in_accept;
    logic                     load_end;
    logic                     issue_en;
    logic                     emit_en;
    logic                     in_stall_int;

    logic                     out_valid_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic [POS_W-1:0]         out_row_reg;
    logic [POS_W-1:0]         out_col_reg;
    logic                     last_reg;

    mme_ctrl_t                ctrl;
    mme_tok_t                 tok_w [MAX_DIM+1];
    logic [DIM_W-1:0]         t_w   [MAX_DIM+1];
    logic signed [PROD_W-1:0] acc_w [MAX_DIM+1];
    logic [MAX_DIM-1:0]       done_w;

    // configuration
    assign cfg_hit = cfg_we && ((cfg_index == CFG_ROWS_M) || (cfg_index == CFG_INNER_K)
                             || (cfg_index == CFG_COLS_N));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= DIM_REG_W'(1);
            inner_k_reg <= DIM_REG_W'(1);
            cols_n_reg  <= DIM_REG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS_M:  rows_m_reg  <= cfg_data;
                CFG_INNER_K: inner_k_reg <= cfg_data;
                CFG_COLS_N:  cols_n_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign m_last = dim_last(rows_m_reg);
    assign k_last = dim_last(inner_k_reg);
    assign n_last = dim_last(cols_n_reg);

    // load position: rows of A then rows of B
    assign ld_i_last = phase_b_reg ? k_last : m_last;
    assign ld_j_last = phase_b_reg ? n_last : k_last;
    assign in_accept = in_valid && !in_stall_int;
    assign load_end  = in_accept && phase_b_reg && (ld_i_reg == k_last)
                       && (ld_j_reg == n_last);

    // state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (!cfg_hit && load_end)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (t_reg == k_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (done_w[MAX_DIM-1])
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (emit_en && (col_reg == n_last))
                begin
                    state_next = (row_reg == m_last) ? ST_LOAD : ST_CALC;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        in_stall_int = 1'b1;
        issue_en     = 1'b0;
        emit_en      = 1'b0;
        unique case (state_reg)
            ST_LOAD: in_stall_int = 1'b0;
            ST_CALC: issue_en     = 1'b1;
            ST_WAIT: ;
            ST_OUT:  emit_en      = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            phase_b_reg   <= 1'b0;
            ld_i_reg      <= '0;
            ld_j_reg      <= '0;
            a_wr_addr_reg <= '0;
            a_rd_addr_reg <= '0;
            t_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit)
            begin
                // new sizes restart the load
                phase_b_reg   <= 1'b0;
                ld_i_reg      <= '0;
                ld_j_reg      <= '0;
                a_wr_addr_reg <= '0;
            end
            else if (in_accept)
            begin
                if (!phase_b_reg)
                begin
                    a_wr_addr_reg <= a_wr_addr_reg + AW'(1);
                end
                if (ld_j_reg == ld_j_last)
                begin
                    ld_j_reg <= '0;
                    if (ld_i_reg == ld_i_last)
                    begin
                        ld_i_reg      <= '0;
                        phase_b_reg   <= !phase_b_reg;
                        a_wr_addr_reg <= '0;
                    end
                    else
                    begin
                        ld_i_reg <= ld_i_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    ld_j_reg <= ld_j_reg + DIM_W'(1);
                end
            end

            if (issue_en)
            begin
                a_rd_addr_reg <= a_rd_addr_reg + AW'(1);
                t_reg         <= (t_reg == k_last) ? '0 : t_reg + DIM_W'(1);
            end

            if (emit_en)
            begin
                if (col_reg == n_last)
                begin
                    col_reg <= '0;
                    if (row_reg == m_last)
                    begin
                        row_reg       <= '0;
                        a_rd_addr_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + DIM_W'(1);
                end
            end
        end
    end

    // A store, registered read feeding the head of the chain
    always_ff @(posedge clk)
    begin
        if (in_accept && !phase_b_reg)
        begin
            a_mem[a_wr_addr_reg] <= element;
        end
        a_rd_reg <= a_mem[a_rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
        end
        else
        begin
            iss_valid_reg <= issue_en;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_first_reg <= (t_reg == '0);
        iss_last_reg  <= (t_reg == k_last);
        iss_t_reg     <= t_reg;
    end

    assign tok_w[0].valid = iss_valid_reg;
    assign tok_w[0].first = iss_first_reg;
    assign tok_w[0].last  = iss_last_reg;
    assign tok_w[0].a     = a_rd_reg;
    assign t_w[0]         = iss_t_reg;
    assign acc_w[MAX_DIM] = '0;

    assign ctrl.shift = emit_en;
    assign ctrl.b_we  = in_accept && phase_b_reg;

    for (genvar g = 0; g < MAX_DIM; g++)
    begin : g_cell
        mme_cell #(
            .MAX_DIM (MAX_DIM),
            .IDX     (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .b_wr_t    (ld_i_reg),
            .b_wr_col  (ld_j_reg),
            .b_wr_data (element),
            .tok_in    (tok_w[g]),
            .t_in      (t_w[g]),
            .tok_out   (tok_w[g+1]),
            .t_out     (t_w[g+1]),
            .acc_in    (acc_w[g+1]),
            .acc_out   (acc_w[g]),
            .done      (done_w[g])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            product_reg <= acc_w[0];
            out_row_reg <= POS_W'(row_reg);
            out_col_reg <= POS_W'(col_reg);
            last_reg    <= (row_reg == m_last) && (col_reg == n_last);
        end
    end

    assign in_stall  = in_stall_int;
    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;

    // final result of the matrix sends the engine back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && (row_reg == m_last) && (col_reg == n_last)) |=> (state_reg == ST_LOAD))
        else $error("engine did not return to loading after the final result");

    // the tail of the chain only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        done_w[MAX_DIM-1] |-> (state_reg == ST_WAIT))
        else $error("chain finished outside the wait state");

    // cells finish one after another, never together
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(done_w))
        else $error("more than one cell finished in the same cycle");

endmodule
